// ===== rtl/core/tcw_pkg.sv =====
// Package for the text console writer: request and response payload types,
// request codes, the command format passed from the front end to the back end.
// No dependencies.
`default_nettype none

package tcw_pkg;

	localparam int CELL_INDEX_W = 11;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;
	localparam int CURSOR_ROW_W = 5;
	localparam int CURSOR_COL_W = 7;
	// widest row and column numbers over the supported screen sizes
	localparam int MAX_ROW_W = 6;
	localparam int MAX_COL_W = 8;
	localparam int CMD_QUEUE_DEPTH = 2;

	localparam logic [1:0] REQ_PUT = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [CHAR_W-1:0]       char_code;
		logic [CELL_INDEX_W-1:0] cell_index;
	} tcw_req_t;

	typedef struct packed {
		logic [CURSOR_ROW_W-1:0] cursor_row;
		logic [CURSOR_COL_W-1:0] cursor_col;
		logic [CELL_W-1:0]       cell_data;
		logic                    did_scroll;
	} tcw_rsp_t;

	typedef enum logic [2:0] {
		CMD_PUT,
		CMD_NEWLINE,
		CMD_READ,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [CHAR_W-1:0]       char_code;
		logic                    in_range;
		logic [MAX_ROW_W-1:0]    row;
		logic [MAX_COL_W-1:0]    col;
	} tcw_cmd_t;

	typedef enum logic [0:0] {
		BK_IDLE,
		BK_READ
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcw_front.sv =====
// Front end: accepts request transactions, splits the cell index into row and
// column by reciprocal multiplication and classifies the request.
// Depends on tcw_pkg.
`default_nettype none

module tcw_front #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  tcw_pkg::tcw_req_t req,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output tcw_pkg::tcw_cmd_t cmd
);
	import tcw_pkg::*;

	localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
	// exact quotient for every 11-bit index
	localparam int DIV_SH = CELL_INDEX_W + $clog2(SCREEN_COLUMNS);
	localparam int RECIP_W = DIV_SH + 1;
	localparam int PROD_W = CELL_INDEX_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((2 ** DIV_SH + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS);

	logic                    valid_s1;
	tcw_req_t                req_s1;
	logic [PROD_W-1:0]       prod_s1;
	logic [CELL_INDEX_W-1:0] quot;
	logic [CELL_INDEX_W-1:0] row_start;
	logic [CELL_INDEX_W-1:0] rem;

	assign req_ready = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
			prod_s1 <= PROD_W'(req.cell_index) * PROD_W'(RECIP);
		end
	end

	always_comb begin
		quot = prod_s1[DIV_SH +: CELL_INDEX_W];
		row_start = CELL_INDEX_W'(quot * CELL_INDEX_W'(SCREEN_COLUMNS));
		rem = req_s1.cell_index - row_start;

		cmd.char_code = req_s1.char_code;
		cmd.in_range = 32'(req_s1.cell_index) < CELL_COUNT;
		cmd.row = MAX_ROW_W'(quot);
		cmd.col = MAX_COL_W'(rem);
		case (req_s1.req_type)
			REQ_PUT: begin
				cmd.kind = (req_s1.char_code == NEWLINE_CHAR) ? CMD_NEWLINE : CMD_PUT;
			end
			REQ_READ: begin
				cmd.kind = CMD_READ;
			end
			REQ_CLEAR: begin
				cmd.kind = CMD_CLEAR;
			end
			default: begin
				cmd.kind = CMD_NOP;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on tcw_pkg.
`default_nettype none

module tcw_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  tcw_pkg::tcw_cmd_t wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output tcw_pkg::tcw_cmd_t rd_data
);
	import tcw_pkg::*;

	localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

	tcw_cmd_t         entries_q [CMD_QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = count_q != CNT_W'(CMD_QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data = entries_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_back.sv =====
// Back end: owns the screen memory, per-row fill counts, the scroll offset,
// the cursor, the attribute register and the response register.
// Depends on tcw_pkg.
`default_nettype none

module tcw_back #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  tcw_pkg::tcw_cmd_t           cmd,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output tcw_pkg::tcw_rsp_t           rsp
);
	import tcw_pkg::*;

	localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int ROW_W = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
	localparam int COL_W = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
	localparam int FILL_W = $clog2(SCREEN_COLUMNS + 1);
	localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(SCREEN_COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);

	back_state_t       state_q, state_d;
	logic [ATTR_W-1:0] attr_q;
	// cursor in screen coordinates and in memory rows
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_prow_q;
	logic [ADDR_W-1:0] cur_base_q;
	// memory row that holds screen row 0
	logic [ROW_W-1:0]  top_q;
	logic [ADDR_W-1:0] top_base_q;
	// cells at or past the fill count of a row read as blanks in its blank attribute
	logic [FILL_W-1:0] fill_q [SCREEN_ROWS];
	logic [ATTR_W-1:0] blank_attr_q [SCREEN_ROWS];

	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rd_data_q;
	logic              rd_in_range_q;
	logic              rd_below_fill_q;
	logic [ATTR_W-1:0] rd_blank_attr_q;

	logic              rsp_valid_q;
	tcw_rsp_t          rsp_q, rsp_d;

	logic              slot_free;
	logic              pop;
	logic              exec;
	logic              load;
	logic              rd_en;
	logic              wr_en;
	logic              adv;
	logic              scroll;
	logic [ROW_W-1:0]  nxt_row, nxt_prow, nxt_top;
	logic [COL_W-1:0]  nxt_col;
	logic [ADDR_W-1:0] nxt_base, nxt_top_base;
	logic [ROW_W-1:0]  prow_inc, top_inc;
	logic [ADDR_W-1:0] base_inc, top_base_inc;
	logic [ADDR_W-1:0] wr_addr;
	logic [ROW_W:0]    rd_prow_sum;
	logic [ROW_W-1:0]  rd_prow;
	logic [ADDR_W:0]   rd_addr_sum;
	logic [ADDR_W-1:0] rd_addr;
	logic [COL_W-1:0]  rd_col;

	assign cfg_ready = 1'b1;
	assign cmd_ready = pop;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		exec = 1'b0;
		load = 1'b0;
		rd_en = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == CMD_READ) begin
						pop = 1'b1;
						rd_en = cmd.in_range;
						state_d = BK_READ;
					end else if (slot_free) begin
						pop = 1'b1;
						exec = 1'b1;
						load = 1'b1;
					end
				end
			end
			BK_READ: begin
				// hold the read data until the response register frees up
				if (slot_free) begin
					load = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// cursor and scroll update for put, newline and clear
	always_comb begin
		prow_inc = (cur_prow_q == LAST_ROW) ? '0 : cur_prow_q + ROW_W'(1);
		top_inc = (top_q == LAST_ROW) ? '0 : top_q + ROW_W'(1);
		base_inc = (cur_base_q == LAST_BASE) ? '0 : cur_base_q + ROW_STRIDE;
		top_base_inc = (top_base_q == LAST_BASE) ? '0 : top_base_q + ROW_STRIDE;

		adv = (cmd.kind == CMD_NEWLINE) || (cmd.kind == CMD_PUT && cur_col_q == LAST_COL);
		scroll = adv && (cur_row_q == LAST_ROW);
		wr_en = exec && (cmd.kind == CMD_PUT);
		wr_addr = cur_base_q + ADDR_W'(cur_col_q);

		nxt_row = cur_row_q;
		nxt_col = cur_col_q;
		nxt_prow = cur_prow_q;
		nxt_base = cur_base_q;
		nxt_top = top_q;
		nxt_top_base = top_base_q;
		if (cmd.kind == CMD_CLEAR) begin
			nxt_row = '0;
			nxt_col = '0;
			nxt_prow = '0;
			nxt_base = '0;
			nxt_top = '0;
			nxt_top_base = '0;
		end else if (adv) begin
			nxt_col = '0;
			if (scroll) begin
				// the old top row becomes the blank bottom row
				nxt_prow = top_q;
				nxt_base = top_base_q;
				nxt_top = top_inc;
				nxt_top_base = top_base_inc;
			end else begin
				nxt_row = cur_row_q + ROW_W'(1);
				nxt_prow = prow_inc;
				nxt_base = base_inc;
			end
		end else if (cmd.kind == CMD_PUT) begin
			nxt_col = cur_col_q + COL_W'(1);
		end
	end

	// map a screen cell to its memory cell through the scroll offset
	always_comb begin
		rd_prow_sum = {1'b0, ROW_W'(cmd.row)} + {1'b0, top_q};
		rd_prow = (rd_prow_sum >= (ROW_W + 1)'(SCREEN_ROWS)) ?
			ROW_W'(rd_prow_sum - (ROW_W + 1)'(SCREEN_ROWS)) : ROW_W'(rd_prow_sum);
		rd_addr_sum = {1'b0, ADDR_W'(cmd.row) * ROW_STRIDE + ADDR_W'(cmd.col)} +
			{1'b0, top_base_q};
		rd_addr = (rd_addr_sum >= (ADDR_W + 1)'(CELL_COUNT)) ?
			ADDR_W'(rd_addr_sum - (ADDR_W + 1)'(CELL_COUNT)) : ADDR_W'(rd_addr_sum);
		rd_col = COL_W'(cmd.col);
	end

	always_comb begin
		if (state_q == BK_READ) begin
			rsp_d.cursor_row = CURSOR_ROW_W'(cur_row_q);
			rsp_d.cursor_col = CURSOR_COL_W'(cur_col_q);
			rsp_d.did_scroll = 1'b0;
			if (!rd_in_range_q) begin
				rsp_d.cell_data = '0;
			end else if (rd_below_fill_q) begin
				rsp_d.cell_data = rd_data_q;
			end else begin
				rsp_d.cell_data = {rd_blank_attr_q, BLANK_CHAR};
			end
		end else begin
			rsp_d.cursor_row = CURSOR_ROW_W'(nxt_row);
			rsp_d.cursor_col = CURSOR_COL_W'(nxt_col);
			rsp_d.cell_data = '0;
			rsp_d.did_scroll = scroll;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
			cur_row_q <= '0;
			cur_col_q <= '0;
			cur_prow_q <= '0;
			cur_base_q <= '0;
			top_q <= '0;
			top_base_q <= '0;
			rsp_valid_q <= 1'b0;
			for (int r = 0; r < SCREEN_ROWS; r++) begin
				fill_q[r] <= '0;
				blank_attr_q[r] <= ATTR_RESET;
			end
		end else begin
			if (cfg_valid) begin
				attr_q <= cfg_data;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (exec) begin
				cur_row_q <= nxt_row;
				cur_col_q <= nxt_col;
				cur_prow_q <= nxt_prow;
				cur_base_q <= nxt_base;
				top_q <= nxt_top;
				top_base_q <= nxt_top_base;
			end
			if (exec && cmd.kind == CMD_CLEAR) begin
				for (int r = 0; r < SCREEN_ROWS; r++) begin
					fill_q[r] <= '0;
					blank_attr_q[r] <= attr_q;
				end
			end else begin
				if (wr_en) begin
					fill_q[cur_prow_q] <= FILL_W'(cur_col_q) + FILL_W'(1);
				end
				// blank the recycled row last so it wins on a one-row screen
				if (exec && scroll) begin
					fill_q[top_q] <= '0;
					blank_attr_q[top_q] <= attr_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {attr_q, cmd.char_code};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.kind == CMD_READ) begin
			rd_in_range_q <= cmd.in_range;
			rd_below_fill_q <= FILL_W'(rd_col) < fill_q[rd_prow];
			rd_blank_attr_q <= blank_attr_q[rd_prow];
		end
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/text_console_writer.sv =====
// Text console writer: screen of SCREEN_ROWS x SCREEN_COLUMNS character cells
// with a cursor. Request channel req_valid/req_ready/req carries put, read and
// clear requests; every request returns exactly one response on
// rsp_valid/rsp_ready/rsp with the cursor after the request, the read cell
// (zero for other requests) and a scroll flag. cfg_valid/cfg_data writes the
// text attribute and is always ready; write it only while the block is idle.
// Path: a put, newline or clear response passes the front stage, the command
// queue and the response register; a read also passes the memory read register.
// Throughput: one put, newline or clear per cycle while rsp_ready stays high;
// a read holds the back end in its read state until the response register frees
// up. Scroll and clear write no memory: scroll rotates a row offset, and per-row
// fill counts make untouched cells read as blanks in their row's blank attribute.
// Reset: cursor home, attribute 7, every cell reads as 0x0720 at once; there
// is no memory sweep.
// Receiver stall: the response register holds; the two-entry command queue
// and the front stage fill, then req_ready drops.
// Depends on tcw_pkg, tcw_front, tcw_cmd_fifo, tcw_back.
`default_nettype none

module text_console_writer #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  tcw_pkg::tcw_req_t           req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output tcw_pkg::tcw_rsp_t           rsp
);
	import tcw_pkg::*;

	logic     front_valid;
	logic     front_ready;
	tcw_cmd_t front_cmd;
	logic     back_valid;
	logic     back_ready;
	tcw_cmd_t back_cmd;

	tcw_front #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready),
		.cmd(front_cmd)
	);

	tcw_cmd_fifo u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(front_valid),
		.wr_ready(front_ready),
		.wr_data(front_cmd),
		.rd_valid(back_valid),
		.rd_ready(back_ready),
		.rd_data(back_cmd)
	);

	tcw_back #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.cmd_valid(back_valid),
		.cmd_ready(back_ready),
		.cmd(back_cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

`ifndef SYNTHESIS
	// a scroll always leaves the cursor at the start of the last row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.did_scroll |->
			rsp.cursor_col == '0 &&
			rsp.cursor_row == CURSOR_ROW_W'(SCREEN_ROWS - 1))
		else $error("scroll response with cursor off the last row start");

	// the front stage keeps its command while the queue is full
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid && !front_ready |=> front_valid && $stable(front_cmd))
		else $error("front command lost while queue full");

	// the back end pops the queue only when the queue holds a command
	a_back_pop: assert property (@(posedge clk) disable iff (!arst_n)
		back_ready |-> back_valid)
		else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire
